[rtl/rac_pkg.sv]
// shared constants and types for the range assign and count block
package rac_pkg;
	localparam int DEF_MAX_ELEMENTS = 65536;
	localparam int DEF_BLOCK_SIZE = 256;
	localparam int LEN_W = 17;
	localparam int IDX_W = 16;
	localparam int VAL_W = 31;
	localparam int CNT_W = 17;

	typedef enum logic [1:0] {
		CMD_LOAD   = 2'd0,
		CMD_ASSIGN = 2'd1,
		CMD_COUNT  = 2'd2,
		CMD_NONE   = 2'd3
	} cmd_t;

	typedef enum logic [6:0] {
		S_IDLE = 7'b0000001,
		S_BLK  = 7'b0000010,
		S_TAG  = 7'b0000100,
		S_PUSH = 7'b0001000,
		S_WALK = 7'b0010000,
		S_NEXT = 7'b0100000,
		S_FIN  = 7'b1000000
	} state_t;
endpackage

[rtl/range_assign_count_equal.sv]
// top level: array of values with range assign and range count equal
//
// input channel in_valid/in_ready carries one command item: command, first_index,
// last_index and value. a count item returns one item on out_valid/out_ready
// holding match_count; load and assign items return nothing.
// the block takes one item at a time; in_ready is high only when idle.
// the work per item grows with the span length of each edge block, + BLOCK_SIZE
// elements when an edge block carries a pending fill and is pushed down, +
// BLOCK_SIZE for each untagged inner block of a count; each block touched also
// passes its block, tag and next states. the single port element memory, one
// element per cycle, sets this cost. an out of range item goes straight to the
// finish state. the result sits in an output register: a new item is accepted
// while it waits, and a following count only stalls at its end until the
// receiver takes it. the user must write length through cfg_write/cfg_data
// only while idle; the block itself does not enforce this. reset clears all
// fill tags and sets length to 65536; element contents are undefined until
// written.
module range_assign_count_equal import rac_pkg::*; #(
	parameter int MAX_ELEMENTS = DEF_MAX_ELEMENTS,
	parameter int BLOCK_SIZE = DEF_BLOCK_SIZE
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_write,
	input  logic [LEN_W-1:0] cfg_data,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [1:0]       command,
	input  logic [IDX_W-1:0] first_index,
	input  logic [IDX_W-1:0] last_index,
	input  logic [VAL_W-1:0] value,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [CNT_W-1:0] match_count
);
	localparam int BLOCK_COUNT = (MAX_ELEMENTS + BLOCK_SIZE - 1) / BLOCK_SIZE;
	localparam int BW = (BLOCK_COUNT > 1) ? $clog2(BLOCK_COUNT) : 1;
	localparam int OW = $clog2(BLOCK_SIZE);
	localparam int AW = $clog2(MAX_ELEMENTS);
	localparam int NW = ($clog2(MAX_ELEMENTS + 1) > LEN_W) ? $clog2(MAX_ELEMENTS + 1) : LEN_W;
	localparam int LAST_OFF = MAX_ELEMENTS - 1 - (BLOCK_COUNT - 1) * BLOCK_SIZE;

	state_t state_q;
	logic [LEN_W-1:0] length_q;
	cmd_t cmd_q;
	logic [VAL_W-1:0] v_q;
	logic [BW-1:0] b1_q, b2_q, cur_blk_q;
	logic [OW-1:0] lo_off_q, hi_off_q, off_q, end_q, push_off_q;
	logic edge_q;
	logic [CNT_W-1:0] acc_q;
	logic rd_s1;
	logic [VAL_W-1:0] val_rd_s1, tag_rd_s1;
	logic [VAL_W-1:0] value_store [MAX_ELEMENTS];
	logic [VAL_W-1:0] tag_mem [BLOCK_COUNT];
	logic [BLOCK_COUNT-1:0] tag_vld_q;

	logic [NW-1:0] eff_n;
	logic ok_rng, ok_ld, accept;
	logic [BW-1:0] in_b1, in_b2;
	logic [31:0] blk_base;
	logic [OW-1:0] push_end, mem_off;
	logic mem_we, tag_we;
	logic [AW-1:0] mem_addr;
	logic [VAL_W-1:0] mem_wd;
	logic [CNT_W-1:0] inc_rd, inc_tag;

	assign in_ready = (state_q == S_IDLE);
	assign accept = in_valid && in_ready;
	assign eff_n = (NW'(length_q) < NW'(MAX_ELEMENTS)) ? NW'(length_q) : NW'(MAX_ELEMENTS);
	assign ok_ld = NW'(first_index) < eff_n;
	assign ok_rng = (first_index <= last_index) && (NW'(last_index) < eff_n);
	assign in_b1 = BW'(32'(first_index) / BLOCK_SIZE);
	assign in_b2 = BW'(32'(last_index) / BLOCK_SIZE);
	assign blk_base = 32'(cur_blk_q) * 32'(BLOCK_SIZE);
	assign push_end = (cur_blk_q == BW'(BLOCK_COUNT - 1)) ? OW'(LAST_OFF) : OW'(BLOCK_SIZE - 1);

	always_comb begin
		mem_off = (state_q == S_PUSH) ? push_off_q : off_q;
		mem_addr = AW'(blk_base + 32'(mem_off));
		mem_wd = (state_q == S_PUSH) ? tag_rd_s1 : v_q;
		mem_we = (state_q == S_PUSH) || ((state_q == S_WALK) && (cmd_q != CMD_COUNT));
		tag_we = (state_q == S_TAG) && !edge_q && (cmd_q == CMD_ASSIGN);
		inc_rd = (rd_s1 && (val_rd_s1 == v_q)) ? CNT_W'(1) : '0;
		inc_tag = ((state_q == S_TAG) && !edge_q && (cmd_q == CMD_COUNT) &&
			tag_vld_q[cur_blk_q] && (tag_rd_s1 == v_q)) ? CNT_W'(BLOCK_SIZE) : '0;
	end

	// element and tag memories
	always_ff @(posedge clk) begin
		if (mem_we) begin
			value_store[mem_addr] <= mem_wd;
		end
		val_rd_s1 <= value_store[mem_addr];
		if (tag_we) begin
			tag_mem[cur_blk_q] <= v_q;
		end
		tag_rd_s1 <= tag_mem[cur_blk_q];
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= cmd_t'(command);
			v_q <= value;
			b1_q <= in_b1;
			b2_q <= (command == CMD_LOAD) ? in_b1 : in_b2;
			lo_off_q <= OW'(32'(first_index) % BLOCK_SIZE);
			hi_off_q <= (command == CMD_LOAD) ? OW'(32'(first_index) % BLOCK_SIZE)
				: OW'(32'(last_index) % BLOCK_SIZE);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			length_q <= LEN_W'(65536);
			tag_vld_q <= '0;
			cur_blk_q <= '0;
			off_q <= '0;
			end_q <= '0;
			push_off_q <= '0;
			edge_q <= 1'b0;
			acc_q <= '0;
			rd_s1 <= 1'b0;
			out_valid <= 1'b0;
			match_count <= '0;
		end else begin
			if (cfg_write) begin
				length_q <= cfg_data;
			end
			if (out_valid && out_ready) begin
				out_valid <= 1'b0;
			end
			rd_s1 <= (state_q == S_WALK) && (cmd_q == CMD_COUNT);
			acc_q <= acc_q + inc_rd + inc_tag;
			case (state_q)
				S_IDLE: begin
					acc_q <= '0;
					cur_blk_q <= in_b1;
					if (accept) begin
						state_q <= S_FIN;
						if ((command == CMD_LOAD && ok_ld) ||
							((command == CMD_ASSIGN || command == CMD_COUNT) && ok_rng)) begin
							state_q <= S_BLK;
						end
					end
				end
				S_BLK: begin
					edge_q <= (cur_blk_q == b1_q) || (cur_blk_q == b2_q);
					off_q <= (cur_blk_q == b1_q) ? lo_off_q : '0;
					end_q <= (cur_blk_q == b2_q) ? hi_off_q : OW'(BLOCK_SIZE - 1);
					push_off_q <= '0;
					state_q <= S_TAG;
				end
				S_TAG: begin
					if (!edge_q) begin
						if (cmd_q == CMD_ASSIGN) begin
							tag_vld_q[cur_blk_q] <= 1'b1;
							state_q <= S_NEXT;
						end else if (tag_vld_q[cur_blk_q]) begin
							state_q <= S_NEXT;
						end else begin
							state_q <= S_WALK;
						end
					end else if (tag_vld_q[cur_blk_q]) begin
						state_q <= S_PUSH;
					end else begin
						state_q <= S_WALK;
					end
				end
				S_PUSH: begin
					push_off_q <= push_off_q + 1'b1;
					if (push_off_q == push_end) begin
						tag_vld_q[cur_blk_q] <= 1'b0;
						state_q <= S_WALK;
					end
				end
				S_WALK: begin
					off_q <= off_q + 1'b1;
					if (off_q == end_q) begin
						state_q <= S_NEXT;
					end
				end
				S_NEXT: begin
					if (cur_blk_q == b2_q) begin
						state_q <= S_FIN;
					end else begin
						cur_blk_q <= cur_blk_q + 1'b1;
						state_q <= S_BLK;
					end
				end
				S_FIN: begin
					if (cmd_q != CMD_COUNT) begin
						state_q <= S_IDLE;
					end else if (!out_valid || out_ready) begin
						out_valid <= 1'b1;
						match_count <= acc_q;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end
endmodule

[rtl/rac_checker.sv]
// port level checks for the range assign and count block
module rac_checker import rac_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             in_valid,
	input logic             in_ready,
	input logic             out_valid,
	input logic             out_ready,
	input logic [CNT_W-1:0] match_count
);
	// result holds while stalled
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(match_count))
		else $error("result item changed while stalled");

	// one item at a time
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("item accepted while busy");

	// count never exceeds the index space
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> match_count <= CNT_W'(65536))
		else $error("match count out of range");

	// a new result only appears after an item was taken
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !in_ready || $past(!in_ready))
		else $error("result item without work");
endmodule

bind range_assign_count_equal rac_checker u_rac_checker (
	.clk(clk),
	.arst_n(arst_n),
	.in_valid(in_valid),
	.in_ready(in_ready),
	.out_valid(out_valid),
	.out_ready(out_ready),
	.match_count(match_count)
);

[dv/range_assign_count_equal_test.sv]
// self-checking testbench for the range assign and count equal block
module range_assign_count_equal_test;
	import rac_pkg::*;

	typedef struct packed {
		cmd_t             cmd;
		logic [IDX_W-1:0] lo;
		logic [IDX_W-1:0] hi;
		logic [VAL_W-1:0] val;
	} rac_item_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             cfg_write = 1'b0;
	logic [LEN_W-1:0] cfg_data = '0;
	logic             in_valid = 1'b0;
	logic             in_ready;
	logic [1:0]       command = '0;
	logic [IDX_W-1:0] first_index = '0;
	logic [IDX_W-1:0] last_index = '0;
	logic [VAL_W-1:0] value = '0;
	logic             out_valid;
	logic             out_ready = 1'b0;
	logic [CNT_W-1:0] match_count;

	rac_item_t        pending_items[$];
	logic [CNT_W-1:0] expected_counts[$];
	logic [VAL_W-1:0] shadow_array[DEF_MAX_ELEMENTS];
	int unsigned      shadow_length = 65536;
	int unsigned      send_idle = 0;
	int unsigned      recv_idle = 0;
	int unsigned      recv_hold = 0;
	int unsigned      error_count = 0;
	logic [VAL_W-1:0] value_pool[8];
	bit               fire;

	range_assign_count_equal dut (
		.clk(clk), .arst_n(arst_n), .cfg_write(cfg_write), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready), .command(command),
		.first_index(first_index), .last_index(last_index), .value(value),
		.out_valid(out_valid), .out_ready(out_ready), .match_count(match_count)
	);

	always #4 clk = ~clk;

	function automatic int unsigned eff_length();
		return shadow_length < DEF_MAX_ELEMENTS ? shadow_length : DEF_MAX_ELEMENTS;
	endfunction

	// applies one command to the flat shadow array; returns 1 when a count result is due
	function automatic bit apply_command(rac_item_t it, output logic [CNT_W-1:0] cnt);
		int unsigned n;
		bit ok;
		n = eff_length();
		ok = (it.lo <= it.hi) && (it.hi < n);
		cnt = '0;
		case (it.cmd)
			CMD_LOAD: begin
				if (it.lo < n)
					shadow_array[it.lo] = it.val;
				return 0;
			end
			CMD_ASSIGN: begin
				if (ok)
					for (int i = it.lo; i <= it.hi; i++)
						shadow_array[i] = it.val;
				return 0;
			end
			CMD_COUNT: begin
				if (ok)
					for (int i = it.lo; i <= it.hi; i++)
						if (shadow_array[i] == it.val)
							cnt++;
				return 1;
			end
			default: return 0;
		endcase
	endfunction

	task automatic report_mismatch(string what, int unsigned got, int unsigned want);
		$display("mismatch: %s got %0d expected %0d", what, got, want);
		error_count++;
	endtask

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			logic [CNT_W-1:0] cnt;
			fire = in_valid && in_ready;
			if (fire) begin
				if (apply_command(pending_items[0], cnt))
					expected_counts.push_back(cnt);
				void'(pending_items.pop_front());
			end
			if (!in_valid || fire) begin
				if (pending_items.size() > 0 && $urandom_range(0, 99) >= send_idle) begin
					in_valid <= 1'b1;
					command <= pending_items[0].cmd;
					first_index <= pending_items[0].lo;
					last_index <= pending_items[0].hi;
					value <= pending_items[0].val;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_counts.size() == 0)
					report_mismatch("unexpected item, match_count", match_count, 0);
				else begin
					if (match_count !== expected_counts[0])
						report_mismatch("match_count", match_count, expected_counts[0]);
					void'(expected_counts.pop_front());
				end
			end
			out_ready <= (recv_hold == 0) && ($urandom_range(0, 99) >= recv_idle);
		end
	end

	always @(posedge clk)
		if (recv_hold > 0)
			recv_hold <= recv_hold - 1;

	function automatic rac_item_t make_item(cmd_t c, int unsigned lo, int unsigned hi,
			logic [VAL_W-1:0] v);
		rac_item_t it;
		it.cmd = c;
		it.lo = lo[IDX_W-1:0];
		it.hi = hi[IDX_W-1:0];
		it.val = v;
		return it;
	endfunction

	function automatic rac_item_t random_item();
		int unsigned n, lo, hi, span, r;
		logic [VAL_W-1:0] v;
		n = eff_length();
		r = $urandom_range(0, 99);
		v = ($urandom_range(0, 3) != 0) ? value_pool[$urandom_range(0, 7)] : VAL_W'($urandom);
		if (r < 8 || n == 0)
			return make_item(cmd_t'($urandom_range(0, 3)), $urandom_range(0, 65535),
				$urandom_range(0, 65535), v);
		lo = $urandom_range(0, n - 1);
		r = $urandom_range(0, 199);
		span = (r < 170) ? $urandom_range(0, 300) : (r < 198) ? $urandom_range(0, 2000)
			: $urandom_range(0, 20000);
		hi = (lo + span < n) ? lo + span : n - 1;
		return make_item(cmd_t'($urandom_range(0, 2)), lo, hi, v);
	endfunction

	task automatic drain();
		wait (pending_items.size() == 0 && expected_counts.size() == 0);
		repeat (600) @(posedge clk);
		while (!in_ready || in_valid) @(posedge clk);
	endtask

	task automatic write_length(int unsigned len);
		drain();
		cfg_write <= 1'b1;
		cfg_data <= len[LEN_W-1:0];
		@(posedge clk);
		cfg_write <= 1'b0;
		shadow_length = len & 32'h1FFFF;
	endtask

	task automatic run_random(int unsigned count);
		for (int i = 0; i < count; i++)
			pending_items.push_back(random_item());
	endtask

	initial begin
		int unsigned lengths[6];
		for (int i = 0; i < 8; i++)
			value_pool[i] = VAL_W'($urandom_range(0, 15));
		value_pool[7] = {VAL_W{1'b1}};
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		send_idle = 10;
		recv_idle = 48;

		// whole array first, so no element is ever read before being written
		pending_items.push_back(make_item(CMD_ASSIGN, 0, 65535, value_pool[0]));
		pending_items.push_back(make_item(CMD_COUNT, 0, 65535, value_pool[0]));
		pending_items.push_back(make_item(CMD_LOAD, 0, 0, {VAL_W{1'b1}}));
		pending_items.push_back(make_item(CMD_LOAD, 65535, 0, '0));
		pending_items.push_back(make_item(CMD_COUNT, 0, 300, {VAL_W{1'b1}}));
		pending_items.push_back(make_item(CMD_ASSIGN, 100, 1500, value_pool[1]));
		pending_items.push_back(make_item(CMD_COUNT, 0, 2000, value_pool[1]));
		pending_items.push_back(make_item(CMD_LOAD, 700, 0, value_pool[2]));
		pending_items.push_back(make_item(CMD_COUNT, 90, 1600, value_pool[1]));
		pending_items.push_back(make_item(CMD_COUNT, 500, 400, value_pool[1]));
		pending_items.push_back(make_item(CMD_ASSIGN, 500, 400, value_pool[3]));
		pending_items.push_back(make_item(CMD_NONE, 65535, 65535, {VAL_W{1'b1}}));
		pending_items.push_back(make_item(CMD_COUNT, 65535, 65535, '0));
		pending_items.push_back(make_item(CMD_COUNT, 0, 65535, value_pool[0]));
		run_random(280);

		// long receiver stall while counts keep coming
		wait (pending_items.size() < 150);
		recv_hold = 3000;
		for (int i = 0; i < 20; i++)
			pending_items.push_back(make_item(CMD_COUNT, i, i + 10, value_pool[i % 8]));
		drain();
		run_random(150);

		lengths = '{1000, 0, 1, 131071, 70000, 0};
		lengths[5] = $urandom_range(2, 65536);
		for (int p = 0; p < 6; p++) begin
			write_length(lengths[p]);
			if (p == 2) begin
				send_idle = 48;
				recv_idle = 10;
			end
			if (p == 4) begin
				send_idle = 0;
				recv_idle = 0;
			end
			pending_items.push_back(make_item(CMD_COUNT, 0, 999, value_pool[0]));
			pending_items.push_back(make_item(CMD_LOAD, 999, 0, value_pool[4]));
			pending_items.push_back(make_item(CMD_LOAD, 1000, 0, value_pool[4]));
			pending_items.push_back(make_item(CMD_COUNT, 0, 0, value_pool[4]));
			run_random(p == 1 ? 30 : 130);
		end

		drain();
		if (error_count == 0)
			$display("range_assign_count_equal_test: clean");
		else
			$display("range_assign_count_equal_test: errors");
		$finish;
	end

	initial begin
		#(8 * 40000000);
		$display("range_assign_count_equal_test: errors");
		$finish;
	end
endmodule
